>>> src/bks_pkg.sv
// Package for the bounded key stack: sizes, operation and status codes,
// sequencer states and the request struct that drives the entry store.
// Used by every module of the block.
package bks_pkg;

  localparam int DEPTH   = 8;
  localparam int KEY_W   = 64;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 4;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OUT_W   = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_CMP,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic we;
    logic wr_from_rd;
    idx_t waddr;
    idx_t raddr;
    key_t key;
  } store_req_t;

endpackage

>>> src/bks_store.sv
// Entry store of the bounded key stack: key memory with a registered read
// port and the shared 64-bit key comparator.
// Depends on bks_pkg.
module bks_store
  import bks_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output logic       hit
);

  key_t mem [DEPTH];
  key_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wr_from_rd ? rdata_r : req.key;
    end
    rdata_r <= mem[req.raddr];
  end

  assign hit = (rdata_r == req.key);

endmodule

>>> src/bks_seq.sv
// Sequencer of the bounded key stack: walks the entries through the shared
// comparator, moves entries down after a remove and holds the result register.
// Depends on bks_pkg.
module bks_seq
  import bks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KEY_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0] in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output store_req_t        req,
  input  logic              hit
);

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  key_t              key_r, key_nxt;
  idx_t              idx_r, idx_nxt;
  cnt_t              fill_r, fill_nxt;
  status_t           status_r, status_nxt;
  logic              present_r, present_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [CNT_W:0]         idx_p1, idx_p2, fill_ext;
  logic [CNT_W+COUNT_W-1:0] fill_wide;
  logic [IDX_W-1:0]       fill_top;

  assign fill_ext  = (CNT_W+1)'(fill_r);
  assign idx_p1    = (CNT_W+1)'(idx_r) + 1'b1;
  assign idx_p2    = (CNT_W+1)'(idx_r) + 2'd2;
  assign fill_top  = IDX_W'(fill_r - 1'b1);
  assign fill_wide = (CNT_W+COUNT_W)'(fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    present_r  <= present_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    status_nxt     = status_r;
    present_nxt    = present_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_data_nxt   = out_data_r;
    in_tready      = 1'b0;
    req.we         = 1'b0;
    req.wr_from_rd = 1'b0;
    req.waddr      = idx_r;
    req.raddr      = idx_r;
    req.key        = key_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          key_nxt     = in_tdata;
          present_nxt = 1'b0;
          status_nxt  = ST_DONE;
          idx_nxt     = fill_top;
          state_nxt   = S_RESULT;
          case (in_tuser)
            OP_PUSH: begin
              if (fill_ext == (CNT_W+1)'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_PUSH;
              end
            end
            OP_REMOVE: begin
              if (fill_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_SEARCH: begin
              if (fill_r == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_PUSH: begin
        req.we    = 1'b1;
        req.waddr = IDX_W'(fill_r);
        fill_nxt  = fill_r + 1'b1;
        state_nxt = S_RESULT;
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          present_nxt = 1'b1;
          if (mode_r == OP_REMOVE) begin
            if (idx_p1 < fill_ext) begin
              req.raddr = IDX_W'(idx_p1);
              state_nxt = S_SHIFT;
            end else begin
              fill_nxt  = fill_r - 1'b1;
              state_nxt = S_RESULT;
            end
          end else begin
            state_nxt = S_RESULT;
          end
        end else if (idx_r == '0) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          req.raddr = idx_r - 1'b1;
        end
      end
      S_SHIFT: begin
        req.we         = 1'b1;
        req.wr_from_rd = 1'b1;
        idx_nxt        = IDX_W'(idx_p1);
        if (idx_p2 < fill_ext) begin
          req.raddr = IDX_W'(idx_p2);
        end else begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({fill_wide[COUNT_W-1:0], present_r, status_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/bounded_key_stack_unit.sv
// Bounded key stack, top level: push, remove-by-key and search on up to DEPTH 64-bit keys.
// Full, empty, no-op and search of an empty stack go straight from accept to the result;
// push writes one entry; search walks entries; remove walks, then moves entries down.
// One transaction at a time: the comparator walks one entry per cycle from a single read port.
// The next transaction is accepted in the cycle after the result register loads.
// Synchronous active-low reset empties the stack and drops any pending result.
module bounded_key_stack_unit
  import bks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KEY_W-1:0]  in_tdata,   // [63:0] key
  input  logic [MODE_W-1:0] in_tuser,   // [1:0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [1:0] status, [2] present, [6:3] count, [7] zero
);

  store_req_t req;
  logic       hit;

  bks_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .req        (req),
    .hit        (hit)
  );

  bks_store u_store (
    .clk (clk),
    .req (req),
    .hit (hit)
  );

endmodule

>>> src/bks_checker.sv
// Port-level checks for the bounded key stack, bound to bounded_key_stack_unit.
// Depends on bks_pkg.
module bks_checker
  import bks_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_present_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == ST_DONE)
    else $error("key found but status not done");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |->
      !out_tdata[2] && out_tdata[6:3] == COUNT_W'(DEPTH))
    else $error("full status with wrong count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bounded_key_stack_unit bks_checker u_bks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/bounded_key_stack_unit_test.sv
// Testbench for bounded_key_stack_unit: directed and random push, remove and search traffic
// checked result by result against an in-bench model of the key stack.
// Depends on bks_pkg and the bounded_key_stack_unit RTL.
module bounded_key_stack_unit_test;
  import bks_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
  localparam key_t KEY_ONES = {KEY_W{1'b1}};

  typedef struct {
    status_t            status;
    logic               present;
    logic [COUNT_W-1:0] count;
  } stack_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [KEY_W-1:0]  in_tdata;   // [63:0] key
  logic [MODE_W-1:0] in_tuser;   // [1:0] mode
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // [1:0] status, [2] present, [6:3] count, [7] zero

  bounded_key_stack_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  key_t          key_store [DEPTH];
  int            key_fill;
  stack_result_t pending_results[$];
  stack_result_t want;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            errors;
  int            cycles;
  int            sent_items;
  int            checked_items;
  int            full_hits;
  int            empty_hits;
  int            miss_hits;
  int            found_hits;
  key_t          key_pool [6];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("** bounded_key_stack_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual tdata=%h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        checked_items++;
        if (out_tdata[1:0] !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tdata[1:0]);
        end
        if (out_tdata[2] !== want.present) begin
          errors++;
          $display("%0t: present expected %0d actual %0d", $time, want.present, out_tdata[2]);
        end
        if (out_tdata[6:3] !== want.count) begin
          errors++;
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_tdata[6:3]);
        end
        if (out_tdata[7] !== 1'b0) begin
          errors++;
          $display("%0t: pad bit expected 0 actual %b", $time, out_tdata[7]);
        end
      end
    end
  end

  function automatic stack_result_t stack_apply(logic [MODE_W-1:0] mode, key_t key);
    stack_result_t res;
    int            pos;
    int            i;
    res.status  = ST_DONE;
    res.present = 1'b0;
    pos = -1;
    case (mode)
      OP_PUSH: begin
        if (key_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          key_store[key_fill] = key;
          key_fill++;
        end
      end
      OP_REMOVE: begin
        if (key_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (i = key_fill - 1; i >= 0; i--)
            if (pos < 0 && key_store[i] == key) pos = i;
          if (pos < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.present = 1'b1;
            for (i = pos; i + 1 < key_fill; i++) key_store[i] = key_store[i+1];
            key_fill--;
          end
        end
      end
      OP_SEARCH: begin
        for (i = key_fill - 1; i >= 0; i--)
          if (key_store[i] == key) pos = i;
        if (pos >= 0) res.present = 1'b1;
        else res.status = ST_NOTFOUND;
      end
      default: begin
      end
    endcase
    res.count = key_fill[COUNT_W-1:0];
    return res;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, key_t key);
    stack_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    res = stack_apply(mode, key);
    pending_results.push_back(res);
    sent_items++;
    case (res.status)
      ST_FULL:     full_hits++;
      ST_EMPTY:    empty_hits++;
      ST_NOTFOUND: miss_hits++;
      default:     if (res.present) found_hits++;
    endcase
  endtask

  task automatic test_directed_cases();
    send_item(OP_SEARCH, '0);
    send_item(OP_REMOVE, '0);
    send_item(MODE_NOP, KEY_ONES);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, KEY_ONES);
    send_item(OP_PUSH, 64'h5555_5555_5555_5555);
    send_item(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, 64'd1);
    send_item(OP_PUSH, 64'h8000_0000_0000_0000);
    send_item(OP_PUSH, 64'h0123_4567_89AB_CDEF);
    send_item(OP_PUSH, 64'd42);
    send_item(MODE_NOP, '0);
    send_item(OP_SEARCH, KEY_ONES);
    send_item(OP_SEARCH, 64'd2);
    send_item(OP_REMOVE, '0);
    send_item(OP_SEARCH, '0);
    send_item(OP_REMOVE, KEY_ONES);
    send_item(OP_REMOVE, 64'd7);
    send_item(OP_REMOVE, 64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct, int n_items);
    int                push_pct;
    int                r;
    int                k;
    key_t              key;
    logic [MODE_W-1:0] mode;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (k = 2; k < 6; k++) key_pool[k] = {$urandom, $urandom};
    push_pct = 45;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) push_pct = $urandom_range(15, 75);
      r = $urandom_range(99);
      if (r < push_pct) mode = OP_PUSH;
      else if (r < push_pct + (95 - push_pct) * 6 / 10) mode = OP_REMOVE;
      else if (r < 95) mode = OP_SEARCH;
      else mode = MODE_NOP;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(5)];
      else key = {$urandom, $urandom};
      send_item(mode, key);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= '0;
    out_tready    <= 1'b0;
    cycles        = 0;
    errors        = 0;
    sent_items    = 0;
    checked_items = 0;
    full_hits     = 0;
    empty_hits    = 0;
    miss_hits     = 0;
    found_hits    = 0;
    key_fill      = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(36, 80, 477);
    test_random_traffic(80, 36, 477);
    test_random_traffic(0, 0, 477);

    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked, %0d mismatches.",
             sent_items, checked_items, errors);
    $display("Hits: %0d found, %0d not found, %0d push on full, %0d remove on empty.",
             found_hits, miss_hits, full_hits, empty_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** bounded_key_stack_unit: PASSED **");
    end else begin
      $display("** bounded_key_stack_unit: FAILED **");
    end
    $finish;
  end

endmodule
